>>> hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
// Depends on nothing; included by rtcde_checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge, reset disables it
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// property checked at every clock edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

>>> hw/rtl/rtcde_pkg.sv
// Types, constants and helper functions of the RTC date to epoch seconds block.
// No dependencies; used by every RTL file of the block.
package rtcde_pkg;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 11;
    localparam int unsigned SECS_W     = 35;
    localparam int unsigned DAYS_W     = 20;
    localparam int unsigned TOD_W      = 20;
    localparam int unsigned PROD_W     = 37;
    localparam int unsigned STAGES     = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_DATA_BINARY  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOUR_MODE_24 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EPOCH_YEAR   = 2'd2;

    localparam logic [CFG_DATA_W-1:0] EPOCH_YEAR_RESET = 11'd1970;

    localparam logic [7:0]  RAW_MIN_WRAP   = 8'd60;
    localparam logic [7:0]  RAW_HOUR_WRAP  = 8'd24;
    localparam logic [7:0]  HALF_DAY_HOURS = 8'd12;
    localparam logic [7:0]  MONTHS_IN_YEAR = 8'd13;
    localparam logic [7:0]  YEAR_2100      = 8'd100;
    localparam logic [7:0]  YEAR_2200      = 8'd200;
    localparam logic [11:0] BASE_YEAR      = 12'd2000;
    localparam logic [9:0]  LEAPS_BEFORE_BASE = 10'd485;
    localparam logic [11:0] ROUND_UP_100   = 12'd99;
    localparam logic [11:0] ROUND_UP_400   = 12'd399;
    localparam logic [11:0] ROUND_UP_4     = 12'd3;
    localparam logic [12:0] RECIP_100      = 13'd5243;
    localparam logic [8:0]  DAYS_PER_YEAR  = 9'd365;
    localparam logic [16:0] SECS_PER_DAY   = 17'd86400;
    localparam logic [11:0] SECS_PER_HOUR  = 12'd3600;
    localparam logic [5:0]  SECS_PER_MIN   = 6'd60;
    localparam logic [3:0]  FULL_YEAR_IDX  = 4'd12;
    localparam logic [3:0]  MARCH_IDX      = 4'd2;
    localparam logic [SECS_W-1:0] SECS_MAX = '1;

    typedef struct packed {
        logic data_binary;
        logic hour_mode_24;
    } mode_t;

    typedef struct packed {
        logic [7:0] second;
        logic [7:0] minute;
        logic [7:0] hour;
        logic [7:0] day;
        logic [7:0] month;
        logic [7:0] year;
    } fields_t;

    function automatic logic [7:0] bcd_byte(input logic [7:0] b);
        logic [7:0] lo;
        logic [7:0] hi;
        lo = {4'd0, b[3:0]};
        hi = {4'd0, b[7:4]} * 8'd10;
        return lo + hi;
    endfunction

    // days before month idx+1 in a common year; idx 12 is the whole year
    function automatic logic [8:0] days_before(input logic [3:0] idx);
        logic [8:0] d;
        unique case (idx)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd59;
            4'd3:    d = 9'd90;
            4'd4:    d = 9'd120;
            4'd5:    d = 9'd151;
            4'd6:    d = 9'd181;
            4'd7:    d = 9'd212;
            4'd8:    d = 9'd243;
            4'd9:    d = 9'd273;
            4'd10:   d = 9'd304;
            4'd11:   d = 9'd334;
            default: d = 9'd365;
        endcase
        return d;
    endfunction

endpackage

>>> hw/rtl/rtcde_if.sv
// Valid/ready channels of the RTC date to epoch seconds block.
// Depends on rtcde_pkg for the result width.
interface rtcde_date_if;
    logic       valid;
    logic       ready;
    logic [7:0] raw_second;
    logic [7:0] raw_minute;
    logic [7:0] raw_hour;
    logic [7:0] raw_day;
    logic [7:0] raw_month;
    logic [7:0] raw_year;

    modport source (output valid, raw_second, raw_minute, raw_hour, raw_day, raw_month,
                    raw_year, input ready);
    modport sink   (input valid, raw_second, raw_minute, raw_hour, raw_day, raw_month,
                    raw_year, output ready);
endinterface

interface rtcde_secs_if;
    logic                        valid;
    logic                        ready;
    logic [rtcde_pkg::SECS_W-1:0] seconds_since_epoch;

    modport source (output valid, seconds_since_epoch, input ready);
    modport sink   (input valid, seconds_since_epoch, output ready);
endinterface

>>> hw/rtl/rtcde_decode.sv
// Field decoder: wrap of raw 60/24 values, BCD decode and 12-hour mapping.
// Depends on rtcde_pkg.
module rtcde_decode
(
    input  rtcde_pkg::fields_t raw,
    input  rtcde_pkg::mode_t   mode,
    output rtcde_pkg::fields_t dec
);

    logic [7:0] sec0;
    logic [7:0] min0;
    logic [7:0] hr0;
    logic [7:0] sec1;
    logic [7:0] min1;
    logic [7:0] hr1;
    logic [7:0] day1;
    logic [7:0] mon1;
    logic [7:0] yr1;
    logic [7:0] h12;
    logic [7:0] hr2;

    assign sec0 = (raw.second == rtcde_pkg::RAW_MIN_WRAP) ? 8'd0 : raw.second;
    assign min0 = (raw.minute == rtcde_pkg::RAW_MIN_WRAP) ? 8'd0 : raw.minute;
    assign hr0  = (raw.hour == rtcde_pkg::RAW_HOUR_WRAP) ? 8'd0 : raw.hour;

    always_comb
    begin
        if (mode.data_binary)
        begin
            sec1 = sec0;
            min1 = min0;
            hr1  = hr0;
            day1 = raw.day;
            mon1 = raw.month;
            yr1  = raw.year;
        end
        else
        begin
            sec1 = rtcde_pkg::bcd_byte(sec0);
            min1 = rtcde_pkg::bcd_byte(min0);
            // PM bit survives the decode
            hr1  = ({4'd0, hr0[3:0]} + {5'd0, hr0[6:4]} * 8'd10) | {hr0[7], 7'd0};
            day1 = rtcde_pkg::bcd_byte(raw.day);
            mon1 = rtcde_pkg::bcd_byte(raw.month);
            yr1  = rtcde_pkg::bcd_byte(raw.year);
        end
    end

    always_comb
    begin
        h12 = {1'b0, hr1[6:0]};
        if (h12 == rtcde_pkg::HALF_DAY_HOURS)
        begin
            h12 = 8'd0;
        end
        if (hr1[7])
        begin
            h12 = h12 + rtcde_pkg::HALF_DAY_HOURS;
        end
        hr2 = mode.hour_mode_24 ? hr1 : h12;
    end

    assign dec.second = (sec1 == rtcde_pkg::RAW_MIN_WRAP) ? 8'd0 : sec1;
    assign dec.minute = min1;
    assign dec.hour   = hr2;
    assign dec.day    = day1;
    assign dec.month  = mon1;
    assign dec.year   = yr1;

endmodule

>>> hw/rtl/rtc_date_to_epoch_seconds_top.sv
// Top level of the RTC date to epoch seconds converter.
// Depends on rtcde_pkg, rtcde_if and rtcde_decode.
//
// Converts one set of raw clock-chip date/time bytes per request into whole
// seconds since January 1 of the configured epoch year. The datapath is a
// six-stage pipeline: decode and reciprocal multiplies, year/leap/month
// terms, year-days multiply and time-of-day sum, day total, days-to-seconds
// multiply, final add with saturation. A new request is taken every cycle unless
// the pipeline is full and the output is stalled. Each stage has its own ready,
// so bubbles are squeezed out while the output is stalled. Registers are written
// through cfg_write_en/cfg_index/cfg_data; the user must write them only while no
// request is in flight, as the block itself does not enforce it.
module rtc_date_to_epoch_seconds_top
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write_en,
    input  logic [rtcde_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rtcde_pkg::CFG_DATA_W-1:0]    cfg_data,
    rtcde_date_if.sink                          date,
    rtcde_secs_if.source                        epoch
);

    localparam int unsigned NS = rtcde_pkg::STAGES;

    logic                              data_binary_reg;
    logic                              hour_mode_24_reg;
    logic [rtcde_pkg::CFG_DATA_W-1:0]  epoch_year_reg;

    logic [NS-1:0] valid_reg;
    logic [NS-1:0] valid_next;
    logic [NS-1:0] stage_ready;

    rtcde_pkg::mode_t   mode;
    rtcde_pkg::fields_t raw;
    rtcde_pkg::fields_t dec_next;

    // stage 1
    rtcde_pkg::fields_t                s1_dec_reg;
    logic [rtcde_pkg::CFG_DATA_W-1:0]  s1_ey_reg;
    logic [9:0]                        s1_ceil4_reg;
    logic [24:0]                       s1_p100_reg;
    logic [24:0]                       s1_p400_reg;
    logic [11:0]                       ey_sum4;
    logic [11:0]                       ey_sum100;
    logic [11:0]                       ey_sum400;

    // stage 2
    logic [11:0] s2_yd_reg;
    logic [9:0]  s2_ldiff_reg;
    logic [8:0]  s2_mdays_reg;
    logic [7:0]  s2_dday_reg;
    logic [19:0] s2_hsec_reg;
    logic [13:0] s2_msec_reg;
    logic [11:0] full_year;
    logic        after_epoch;
    logic        leap;
    logic [8:0]  yr_sum4;
    logic [9:0]  leaps_year;
    logic [9:0]  leaps_epoch;
    logic [3:0]  mon_idx;
    logic [11:0] yd_next;
    logic [9:0]  ldiff_next;
    logic [8:0]  mdays_next;
    logic [7:0]  dday_next;

    // stage 3
    logic [20:0]                  s3_yd365_reg;
    logic [10:0]                  s3_extra_reg;
    logic [rtcde_pkg::TOD_W-1:0]  s3_tod_reg;

    // stage 4
    logic [rtcde_pkg::DAYS_W-1:0] s4_days_reg;
    logic [rtcde_pkg::TOD_W-1:0]  s4_tod_reg;

    // stage 5
    logic [rtcde_pkg::PROD_W-1:0] s5_prod_reg;
    logic [rtcde_pkg::TOD_W-1:0]  s5_tod_reg;

    // stage 6
    logic [rtcde_pkg::SECS_W-1:0] s6_secs_reg;
    logic [rtcde_pkg::PROD_W-1:0] total_next;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_binary_reg  <= 1'b0;
            hour_mode_24_reg <= 1'b1;
            epoch_year_reg   <= rtcde_pkg::EPOCH_YEAR_RESET;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                rtcde_pkg::CFG_DATA_BINARY:  data_binary_reg  <= cfg_data[0];
                rtcde_pkg::CFG_HOUR_MODE_24: hour_mode_24_reg <= cfg_data[0];
                rtcde_pkg::CFG_EPOCH_YEAR:   epoch_year_reg   <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // pipeline control
    always_comb
    begin
        stage_ready[NS-1] = !valid_reg[NS-1] || epoch.ready;
        for (int i = NS - 2; i >= 0; i--)
        begin
            stage_ready[i] = !valid_reg[i] || stage_ready[i+1];
        end
        valid_next[0] = stage_ready[0] ? date.valid : valid_reg[0];
        for (int i = 1; i < NS; i++)
        begin
            valid_next[i] = stage_ready[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign date.ready          = stage_ready[0];
    assign epoch.valid         = valid_reg[NS-1];
    assign epoch.seconds_since_epoch = s6_secs_reg;

    // stage 1: decode, epoch leap-count reciprocals
    assign mode.data_binary  = data_binary_reg;
    assign mode.hour_mode_24 = hour_mode_24_reg;
    assign raw.second = date.raw_second;
    assign raw.minute = date.raw_minute;
    assign raw.hour   = date.raw_hour;
    assign raw.day    = date.raw_day;
    assign raw.month  = date.raw_month;
    assign raw.year   = date.raw_year;

    rtcde_decode u_decode
    (
        .raw  (raw),
        .mode (mode),
        .dec  (dec_next)
    );

    assign ey_sum4   = {1'b0, epoch_year_reg} + rtcde_pkg::ROUND_UP_4;
    assign ey_sum100 = {1'b0, epoch_year_reg} + rtcde_pkg::ROUND_UP_100;
    assign ey_sum400 = {1'b0, epoch_year_reg} + rtcde_pkg::ROUND_UP_400;

    always_ff @(posedge clk)
    begin
        if (stage_ready[0])
        begin
            s1_dec_reg   <= dec_next;
            s1_ey_reg    <= epoch_year_reg;
            s1_ceil4_reg <= ey_sum4[11:2];
            s1_p100_reg  <= {1'b0, ey_sum100} * {12'd0, rtcde_pkg::RECIP_100};
            s1_p400_reg  <= {1'b0, ey_sum400} * {12'd0, rtcde_pkg::RECIP_100};
        end
    end

    // stage 2: whole years, leap difference, month and day offsets
    always_comb
    begin
        full_year   = rtcde_pkg::BASE_YEAR + {4'd0, s1_dec_reg.year};
        after_epoch = full_year > {1'b0, s1_ey_reg};
        // calendar year is 2000..2255: only 2100 and 2200 break the 4-year rule
        leap = (s1_dec_reg.year[1:0] == 2'b00) && (s1_dec_reg.year != rtcde_pkg::YEAR_2100)
            && (s1_dec_reg.year != rtcde_pkg::YEAR_2200);
        yr_sum4    = {1'b0, s1_dec_reg.year} + 9'd3;
        leaps_year = rtcde_pkg::LEAPS_BEFORE_BASE + {3'd0, yr_sum4[8:2]}
            - {9'd0, (s1_dec_reg.year > rtcde_pkg::YEAR_2100)}
            - {9'd0, (s1_dec_reg.year > rtcde_pkg::YEAR_2200)};
        leaps_epoch = s1_ceil4_reg - {4'd0, s1_p100_reg[24:19]}
            + {6'd0, s1_p400_reg[24:21]};
        yd_next    = after_epoch ? (full_year - {1'b0, s1_ey_reg}) : 12'd0;
        ldiff_next = after_epoch ? (leaps_year - leaps_epoch) : 10'd0;

        if (s1_dec_reg.month >= rtcde_pkg::MONTHS_IN_YEAR)
        begin
            mon_idx = rtcde_pkg::FULL_YEAR_IDX;
        end
        else
        begin
            mon_idx = 4'(s1_dec_reg.month - 8'd1);
        end
        if (s1_dec_reg.month == 8'd0)
        begin
            mdays_next = 9'd0;
        end
        else
        begin
            mdays_next = rtcde_pkg::days_before(mon_idx)
                + {8'd0, (leap && (mon_idx >= rtcde_pkg::MARCH_IDX))};
        end
        dday_next = (s1_dec_reg.day == 8'd0) ? 8'd0 : (s1_dec_reg.day - 8'd1);
    end

    always_ff @(posedge clk)
    begin
        if (stage_ready[1])
        begin
            s2_yd_reg    <= yd_next;
            s2_ldiff_reg <= ldiff_next;
            s2_mdays_reg <= mdays_next;
            s2_dday_reg  <= dday_next;
            s2_hsec_reg  <= {12'd0, s1_dec_reg.hour} * {8'd0, rtcde_pkg::SECS_PER_HOUR};
            s2_msec_reg  <= {6'd0, s1_dec_reg.minute} * {8'd0, rtcde_pkg::SECS_PER_MIN}
                + {6'd0, s1_dec_reg.second};
        end
    end

    // stage 3
    always_ff @(posedge clk)
    begin
        if (stage_ready[2])
        begin
            s3_yd365_reg <= {9'd0, s2_yd_reg} * {12'd0, rtcde_pkg::DAYS_PER_YEAR};
            s3_extra_reg <= {1'b0, s2_ldiff_reg} + {2'd0, s2_mdays_reg} + {3'd0, s2_dday_reg};
            s3_tod_reg   <= s2_hsec_reg + {6'd0, s2_msec_reg};
        end
    end

    // stage 4
    always_ff @(posedge clk)
    begin
        if (stage_ready[3])
        begin
            s4_days_reg <= s3_yd365_reg[rtcde_pkg::DAYS_W-1:0]
                + {{(rtcde_pkg::DAYS_W-11){1'b0}}, s3_extra_reg};
            s4_tod_reg  <= s3_tod_reg;
        end
    end

    // stage 5
    always_ff @(posedge clk)
    begin
        if (stage_ready[4])
        begin
            s5_prod_reg <= {17'd0, s4_days_reg} * {20'd0, rtcde_pkg::SECS_PER_DAY};
            s5_tod_reg  <= s4_tod_reg;
        end
    end

    // stage 6: final sum, saturate
    assign total_next = s5_prod_reg
        + {{(rtcde_pkg::PROD_W-rtcde_pkg::TOD_W){1'b0}}, s5_tod_reg};

    always_ff @(posedge clk)
    begin
        if (stage_ready[5])
        begin
            if (total_next[rtcde_pkg::PROD_W-1:rtcde_pkg::SECS_W] != '0)
            begin
                s6_secs_reg <= rtcde_pkg::SECS_MAX;
            end
            else
            begin
                s6_secs_reg <= total_next[rtcde_pkg::SECS_W-1:0];
            end
        end
    end

endmodule

>>> hw/rtl/rtcde_checker.sv
// Port-level checker for the RTC date to epoch seconds top, bound to it below.
// Depends on rtcde_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rtcde_checker
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         date_valid,
    input logic                         date_ready,
    input logic                         epoch_valid,
    input logic                         epoch_ready,
    input logic [rtcde_pkg::SECS_W-1:0] seconds
);

    `ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |-> !epoch_valid)

    `ASSERT_CLK(a_ready_through, clk, rst_n, epoch_ready |-> date_ready)

    // result reaches the output when the output does not stall after its request is taken
    `ASSERT_CLK(a_latency, clk, rst_n, (date_valid && date_ready) ##1 epoch_ready [*5] |=> epoch_valid)

    `ASSERT_CLK(a_stall_hold, clk, rst_n, (epoch_valid && !epoch_ready) |=> (epoch_valid && $stable(seconds)))

endmodule

bind rtc_date_to_epoch_seconds_top rtcde_checker u_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .date_valid  (date.valid),
    .date_ready  (date.ready),
    .epoch_valid (epoch.valid),
    .epoch_ready (epoch.ready),
    .seconds     (epoch.seconds_since_epoch)
);

>>> tb/sv/rtc_date_to_epoch_seconds_top_tb.sv
`timescale 1ns / 100ps
// Testbench for rtc_date_to_epoch_seconds_top: directed table plus random requests,
// each result checked against a known value or a predictor. Depends on rtcde_pkg, rtcde_if.
module rtc_date_to_epoch_seconds_top_tb;

    typedef struct {
        bit                               binary;
        bit                               h24;
        logic [rtcde_pkg::CFG_DATA_W-1:0] epoch;
        rtcde_pkg::fields_t               req;
        bit                               known;
        logic [rtcde_pkg::SECS_W-1:0]     want;
    } dir_row_t;

    logic                             clk;
    logic                             rst_n;
    logic                             cfg_write_en;
    logic [rtcde_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [rtcde_pkg::CFG_DATA_W-1:0] cfg_data;

    rtcde_date_if date_ch ();
    rtcde_secs_if secs_ch ();

    rtc_date_to_epoch_seconds_top u_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .date         (date_ch),
        .epoch        (secs_ch)
    );

    bit                           cur_binary = 1'b0;
    bit                           cur_h24    = 1'b1;
    int unsigned                  cur_epoch  = 1970;
    logic [rtcde_pkg::SECS_W-1:0] expected_secs_q[$];
    dir_row_t                     dir_rows[$];
    int                           fail_count;
    int                           results_checked;
    int                           requests_sent;
    int                           settings_count;
    bit                           src_idle_on;
    bit                           sink_stall_on;
    int                           sink_hold;
    int unsigned                  month_start[13] = '{0, 31, 59, 90, 120, 151, 181, 212,
                                                      243, 273, 304, 334, 365};

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #(10_000_000);
        $display("FAILURE");
        $finish;
    end

    task automatic report_fail(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        fail_count++;
    endtask

    function automatic int unsigned bcd_value(input int unsigned b);
        return ((b & 15) + (b >> 4) * 10) & 255;
    endfunction

    function automatic logic [7:0] to_bcd(input int unsigned v);
        logic [7:0] r;
        r = 8'(((v / 10) << 4) | (v % 10));
        return r;
    endfunction

    function automatic longint unsigned leaps_before_year(input int unsigned y);
        return 64'((y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400);
    endfunction

    function automatic logic [rtcde_pkg::SECS_W-1:0] epoch_seconds_of(
        input rtcde_pkg::fields_t f);
        int unsigned       s;
        int unsigned       m;
        int unsigned       h;
        int unsigned       d;
        int unsigned       mo;
        int unsigned       y;
        int unsigned       yf;
        int unsigned       idx;
        bit                pm;
        longint unsigned   days;
        longint unsigned   total;
        s = 32'(f.second);
        m = 32'(f.minute);
        h = 32'(f.hour);
        d = 32'(f.day);
        mo = 32'(f.month);
        y = 32'(f.year);
        days = 0;
        if (s == 60) s = 0;
        if (m == 60) m = 0;
        if (h == 24) h = 0;
        if (!cur_binary)
        begin
            s = bcd_value(s);
            m = bcd_value(m);
            h = ((h & 15) + ((h >> 4) & 7) * 10) | (h & 128);
            d = bcd_value(d);
            mo = bcd_value(mo);
            y = bcd_value(y);
        end
        if (!cur_h24)
        begin
            pm = (h & 128) != 0;
            h = h & 127;
            if (h == 12) h = 0;
            if (pm) h = h + 12;
        end
        if (s == 60) s = 0;
        yf = 2000 + y;
        if (yf > cur_epoch)
            days = 365 * (yf - cur_epoch) + leaps_before_year(yf) - leaps_before_year(cur_epoch);
        if (mo >= 1)
        begin
            idx = (mo > 13) ? 12 : mo - 1;
            days += month_start[idx];
            if (idx >= 2 && (((yf % 4) == 0 && (yf % 100) != 0) || (yf % 400) == 0))
                days += 1;
        end
        if (d >= 1) days += d - 1;
        total = days * 86400 + h * 3600 + m * 60 + s;
        if (total > 64'h7_FFFF_FFFF) total = 64'h7_FFFF_FFFF;
        return total[rtcde_pkg::SECS_W-1:0];
    endfunction

    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 8);
        return $urandom_range(12, 40);
    endfunction

    function automatic rtcde_pkg::fields_t make_request(input bit noise);
        rtcde_pkg::fields_t f;
        int unsigned        hv;
        if (noise)
        begin
            f.second = 8'($urandom_range(0, 255));
            f.minute = 8'($urandom_range(0, 255));
            f.hour   = 8'($urandom_range(0, 255));
            f.day    = 8'($urandom_range(0, 255));
            f.month  = 8'($urandom_range(0, 255));
            f.year   = 8'($urandom_range(0, 255));
            return f;
        end
        f.second = cur_binary ? 8'($urandom_range(0, 59)) : to_bcd($urandom_range(0, 59));
        f.minute = cur_binary ? 8'($urandom_range(0, 59)) : to_bcd($urandom_range(0, 59));
        f.day    = cur_binary ? 8'($urandom_range(1, 31)) : to_bcd($urandom_range(1, 31));
        f.month  = cur_binary ? 8'($urandom_range(1, 12)) : to_bcd($urandom_range(1, 12));
        f.year   = cur_binary ? 8'($urandom_range(0, 255)) : to_bcd($urandom_range(0, 99));
        if (cur_h24)
        begin
            hv = $urandom_range(0, 23);
            f.hour = cur_binary ? 8'(hv) : to_bcd(hv);
        end
        else
        begin
            hv = $urandom_range(1, 12);
            f.hour = cur_binary ? 8'(hv) : to_bcd(hv);
            f.hour[7] = 1'($urandom_range(0, 1));
        end
        // raw wrap values of the clock chip
        if ($urandom_range(0, 19) == 0) f.second = 8'd60;
        if ($urandom_range(0, 19) == 0) f.minute = 8'd60;
        if (cur_h24 && $urandom_range(0, 19) == 0) f.hour = 8'd24;
        return f;
    endfunction

    task automatic add_row(input bit b, input bit h, input int unsigned ey,
                           input logic [7:0] s, input logic [7:0] m, input logic [7:0] hr,
                           input logic [7:0] d, input logic [7:0] mo, input logic [7:0] y,
                           input bit known, input longint unsigned want);
        dir_row_t r;
        r.binary = b;
        r.h24 = h;
        r.epoch = ey[rtcde_pkg::CFG_DATA_W-1:0];
        r.req.second = s;
        r.req.minute = m;
        r.req.hour = hr;
        r.req.day = d;
        r.req.month = mo;
        r.req.year = y;
        r.known = known;
        r.want = want[rtcde_pkg::SECS_W-1:0];
        dir_rows.push_back(r);
    endtask

    // called and returns at a falling edge
    task automatic apply_mode(input bit b, input bit h, input int unsigned ey);
        cfg_write_en <= 1'b1;
        cfg_index    <= rtcde_pkg::CFG_DATA_BINARY;
        cfg_data     <= {{(rtcde_pkg::CFG_DATA_W-1){1'b0}}, b};
        @(negedge clk);
        cfg_index    <= rtcde_pkg::CFG_HOUR_MODE_24;
        cfg_data     <= {{(rtcde_pkg::CFG_DATA_W-1){1'b0}}, h};
        @(negedge clk);
        cfg_index    <= rtcde_pkg::CFG_EPOCH_YEAR;
        cfg_data     <= ey[rtcde_pkg::CFG_DATA_W-1:0];
        @(negedge clk);
        cfg_write_en <= 1'b0;
        cur_binary = b;
        cur_h24 = h;
        cur_epoch = ey & 11'h7FF;
        settings_count++;
    endtask

    task automatic wait_results_done();
        date_ch.valid <= 1'b0;
        while (expected_secs_q.size() != 0)
            @(posedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic push_request(input rtcde_pkg::fields_t f, input bit known,
                                input logic [rtcde_pkg::SECS_W-1:0] want);
        int unsigned gap;
        gap = (src_idle_on && $urandom_range(0, 99) < 30) ? gap_len() : 0;
        if (gap != 0)
        begin
            date_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        date_ch.valid      <= 1'b1;
        date_ch.raw_second <= f.second;
        date_ch.raw_minute <= f.minute;
        date_ch.raw_hour   <= f.hour;
        date_ch.raw_day    <= f.day;
        date_ch.raw_month  <= f.month;
        date_ch.raw_year   <= f.year;
        do
            @(posedge clk);
        while (date_ch.ready !== 1'b1);
        expected_secs_q.push_back(known ? want : epoch_seconds_of(f));
        requests_sent++;
        @(negedge clk);
    endtask

    always @(negedge clk)
    begin
        if (sink_hold > 0)
        begin
            secs_ch.ready <= 1'b0;
            sink_hold = sink_hold - 1;
        end
        else if (sink_stall_on && $urandom_range(0, 99) < 30)
        begin
            secs_ch.ready <= 1'b0;
            sink_hold = gap_len() - 1;
        end
        else
            secs_ch.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        logic [rtcde_pkg::SECS_W-1:0] want;
        if (rst_n === 1'b1 && secs_ch.valid === 1'b1 && secs_ch.ready === 1'b1)
        begin
            if (expected_secs_q.size() == 0)
                report_fail($sformatf("unexpected result %0d", secs_ch.seconds_since_epoch));
            else
            begin
                want = expected_secs_q.pop_front();
                results_checked++;
                if (secs_ch.seconds_since_epoch !== want)
                    report_fail($sformatf("seconds_since_epoch %0d, expected %0d",
                                          secs_ch.seconds_since_epoch, want));
            end
        end
    end

    initial
    begin
        int          directed_sent;
        int unsigned ey;
        dir_row_t    r;
        rst_n              = 1'b0;
        cfg_write_en       = 1'b0;
        cfg_index          = rtcde_pkg::CFG_DATA_BINARY;
        cfg_data           = '0;
        date_ch.valid      = 1'b0;
        date_ch.raw_second = '0;
        date_ch.raw_minute = '0;
        date_ch.raw_hour   = '0;
        date_ch.raw_day    = '0;
        date_ch.raw_month  = '0;
        date_ch.raw_year   = '0;
        secs_ch.ready      = 1'b0;
        sink_hold          = 0;
        src_idle_on        = 1'b1;
        sink_stall_on      = 1'b1;

        // reset setting: BCD, 24-hour, epoch 1970
        add_row(0, 1, 1970, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1, 946684800);
        add_row(0, 1, 1970, 8'h3C, 8'h00, 8'h00, 8'h01, 8'h01, 8'h00, 1, 946684800);
        add_row(0, 1, 1970, 8'h60, 8'h00, 8'h00, 8'h01, 8'h01, 8'h00, 1, 946684800);
        add_row(0, 1, 1970, 8'h5A, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1, 946684800);
        add_row(0, 1, 1970, 8'h00, 8'h3C, 8'h00, 8'h00, 8'h00, 8'h00, 1, 946684800);
        add_row(0, 1, 1970, 8'h00, 8'h00, 8'h18, 8'h00, 8'h00, 8'h00, 1, 946684800);
        add_row(0, 1, 1970, 8'h00, 8'h00, 8'h80, 8'h00, 8'h00, 8'h00, 1, 947145600);
        add_row(0, 1, 1970, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 0, 0);
        add_row(0, 1, 1970, 8'hAF, 8'hAF, 8'hAF, 8'hAF, 8'hAF, 8'hAF, 0, 0);
        add_row(0, 1, 1970, 8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h99, 0, 0);
        add_row(0, 1, 1970, 8'h00, 8'h00, 8'h00, 8'h01, 8'h13, 8'h00, 0, 0);
        add_row(0, 1, 1970, 8'h00, 8'h00, 8'h00, 8'h01, 8'h14, 8'h01, 0, 0);
        add_row(0, 1, 1970, 8'h00, 8'h00, 8'h00, 8'h01, 8'h03, 8'h00, 0, 0);
        add_row(1, 1, 1970, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1, 946684800);
        add_row(1, 1, 1970, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 0, 0);
        add_row(1, 1, 1970, 8'd0, 8'd0, 8'd0, 8'd1, 8'd3, 8'd100, 0, 0);
        add_row(1, 1, 1970, 8'd255, 8'd255, 8'd200, 8'd31, 8'd12, 8'd200, 0, 0);
        // 12-hour mode: 12 AM is hour 0, 12 PM is hour 12
        add_row(0, 0, 1970, 8'h00, 8'h00, 8'h12, 8'h00, 8'h00, 8'h00, 1, 946684800);
        add_row(0, 0, 1970, 8'h00, 8'h00, 8'h92, 8'h00, 8'h00, 8'h00, 1, 946728000);
        add_row(0, 0, 1970, 8'h00, 8'h00, 8'h81, 8'h15, 8'h06, 8'h24, 0, 0);
        add_row(0, 0, 1970, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, 0, 0);
        add_row(1, 0, 1900, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1, 64'd3155673600);
        add_row(1, 0, 1900, 8'd59, 8'd59, 8'h8C, 8'd31, 8'd12, 8'd255, 0, 0);
        add_row(0, 1, 2000, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1, 0);
        // epoch after the calendar year: no whole years
        add_row(0, 1, 2047, 8'h00, 8'h00, 8'h00, 8'h03, 8'h02, 8'h25, 1, 2851200);

        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        foreach (dir_rows[i])
        begin
            r = dir_rows[i];
            if (r.binary != cur_binary || r.h24 != cur_h24 || r.epoch != cur_epoch)
            begin
                wait_results_done();
                apply_mode(r.binary, r.h24, 32'(r.epoch));
            end
            push_request(r.req, r.known, r.want);
        end
        directed_sent = requests_sent;

        for (int p = 0; p < 8; p++)
        begin
            wait_results_done();
            if (p == 0)
                ey = 1900;
            else if (p == 1)
                ey = 2000;
            else if (p == 7)
                ey = $urandom_range(2001, 2047);
            else
                ey = $urandom_range(1900, 2000);
            apply_mode(p[0], p[1], ey);
            src_idle_on = (p % 4) != 3;
            sink_stall_on = (p % 3) != 2;
            for (int k = 0; k < 113; k++)
            begin
                if (p == 2 && k == 56)
                    wait_results_done();
                push_request(make_request($urandom_range(0, 99) < 20), 1'b0, '0);
            end
        end

        wait_results_done();
        repeat (10) @(posedge clk);
        if (expected_secs_q.size() != 0)
            report_fail($sformatf("%0d results never arrived", expected_secs_q.size()));
        $display("Sent %0d requests (%0d from the table) under %0d register settings,",
                 requests_sent, directed_sent, settings_count);
        $display("BCD and binary, 12- and 24-hour, epochs 1900..2047; %0d results compared.",
                 results_checked);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/rtcde_pkg.sv
hw/rtl/rtcde_if.sv
hw/rtl/rtcde_decode.sv
hw/rtl/rtc_date_to_epoch_seconds_top.sv
hw/rtl/rtcde_checker.sv
tb/sv/rtc_date_to_epoch_seconds_top_tb.sv
